// File: sv/assert_macros.svh
// Assertion macros for the RTL files (included by e2rm_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: sv/e2rm_pkg.sv
// Package: types, constants and helpers of the Euler to rotation matrix block
`default_nettype none
package e2rm_pkg;
    localparam int CordicIterations = 24;
    localparam int AngleW = 25;
    localparam int ElemW = 32;
    localparam int QueueDepth = 4;
    localparam int QueueAw = 2;

    typedef enum logic [2:0] {
        ORDER_XYZ = 3'd0,
        ORDER_ZYX = 3'd1,
        ORDER_YZX = 3'd2,
        ORDER_YXZ = 3'd3,
        ORDER_XZY = 3'd4
    } order_t;

    typedef logic signed [AngleW-1:0] angle_t;
    typedef logic signed [ElemW-1:0] elem_t;

    // Front to back queue entry: phases and order
    typedef struct packed {
        logic [31:0] ph_x;
        logic [31:0] ph_y;
        logic [31:0] ph_z;
        logic [2:0]  order;
    } job_t;

    typedef struct packed {
        elem_t m00; elem_t m01; elem_t m02;
        elem_t m10; elem_t m11; elem_t m12;
        elem_t m20; elem_t m21; elem_t m22;
    } mat_t;

    function automatic logic signed [40:0] atan_val(input int i);
        logic signed [40:0] r;
        begin
            case (i)
                0: r = 41'sd536870912;  1: r = 41'sd316933406;
                2: r = 41'sd167458907;  3: r = 41'sd85004756;
                4: r = 41'sd42667331;   5: r = 41'sd21354465;
                6: r = 41'sd10679838;   7: r = 41'sd5340245;
                8: r = 41'sd2670163;    9: r = 41'sd1335087;
                10: r = 41'sd667544;    11: r = 41'sd333772;
                12: r = 41'sd166886;    13: r = 41'sd83443;
                14: r = 41'sd41722;     15: r = 41'sd20861;
                16: r = 41'sd10430;     17: r = 41'sd5215;
                18: r = 41'sd2608;      19: r = 41'sd1304;
                20: r = 41'sd652;       21: r = 41'sd326;
                22: r = 41'sd163;       23: r = 41'sd81;
                24: r = 41'sd41;        25: r = 41'sd20;
                26: r = 41'sd10;        27: r = 41'sd5;
                28: r = 41'sd3;         29: r = 41'sd1;
                30: r = 41'sd1;
                default: r = 41'sd0;
            endcase
            return r;
        end
    endfunction

    // Saturate a wide value to [-2^30, 2^30]
    function automatic logic signed [31:0] sat_q30(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd1073741824) r = 32'sd1073741824;
            else if (v < -64'sd1073741824) r = -32'sd1073741824;
            else r = v[31:0];
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// File: sv/e2rm_if.sv
// Valid/ready channel interfaces for angles and matrices
`default_nettype none
interface e2rm_angle_if;
    import e2rm_pkg::*;
    logic valid;
    logic ready;
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2rm_mat_if;
    import e2rm_pkg::*;
    logic valid;
    logic ready;
    elem_t m00; elem_t m01; elem_t m02;
    elem_t m10; elem_t m11; elem_t m12;
    elem_t m20; elem_t m21; elem_t m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface
`default_nettype wire

// File: sv/e2rm_front.sv
// Front part: degree to phase conversion, one item per cycle while the output is not stalled
`default_nettype none
module e2rm_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [2:0] order,
    e2rm_angle_if.sink in_ch,
    output logic out_valid,
    input  wire logic out_ready,
    output e2rm_pkg::job_t out_job
);
    import e2rm_pkg::*;

    logic  s1_valid_reg;
    job_t  s1_job_reg;
    logic  s1_adv;

    // Phase = round(a*65536/360) mod 2^32, via reciprocal multiply and fix-up.
    // The offset of 360 * 2^32 keeps the dividend positive and leaves the phase
    // unchanged modulo a full turn.
    function automatic logic [31:0] to_phase(input angle_t a);
        logic signed [47:0] num;
        logic [47:0] un;
        logic [79:0] prod;
        logic [47:0] q;
        logic [47:0] rem;
        begin
            num = 48'(signed'(a)) * 48'sd65536 + 48'sd180 + 48'sd1546188226560;
            un = num;
            prod = 80'(un) * 80'd3054198966;
            q = 48'(prod >> 40);
            rem = un - 48'(q * 48'd360);
            if (rem >= 48'd360) q = q + 48'd1;
            return q[31:0];
        end
    endfunction

    assign s1_adv = !s1_valid_reg || out_ready;
    assign in_ch.ready = s1_adv;
    assign out_valid = s1_valid_reg;
    assign out_job = s1_job_reg;

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_ch.valid)
        begin
            s1_job_reg.ph_x <= to_phase(in_ch.angle_x);
            s1_job_reg.ph_y <= to_phase(in_ch.angle_y);
            s1_job_reg.ph_z <= to_phase(in_ch.angle_z);
            s1_job_reg.order <= order;
        end
    end
endmodule
`default_nettype wire

// File: sv/e2rm_queue.sv
// Short queue between front and back parts
`default_nettype none
module e2rm_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  e2rm_pkg::job_t in_job,
    output logic out_valid,
    input  wire logic out_ready,
    output e2rm_pkg::job_t out_job
);
    import e2rm_pkg::*;

    job_t mem_reg [QueueDepth];
    logic [QueueAw-1:0] wr_reg, rd_reg;
    logic [QueueAw:0] cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != QueueAw'(0) + (QueueAw+1)'(QueueDepth);
    assign out_valid = cnt_reg != '0;
    assign out_job = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= in_job;
    end
endmodule
`default_nettype wire

// File: sv/e2rm_cordic.sv
// Pipelined CORDIC: one rotation step per stage, three axes side by side
`default_nettype none
module e2rm_cordic (
    input  wire logic clk,
    input  wire logic en,
    input  wire logic [31:0] ph_x,
    input  wire logic [31:0] ph_y,
    input  wire logic [31:0] ph_z,
    output logic signed [31:0] cs [3],
    output logic signed [31:0] sn [3]
);
    import e2rm_pkg::*;

    logic signed [40:0] x_reg [CordicIterations+1][3];
    logic signed [40:0] y_reg [CordicIterations+1][3];
    logic signed [40:0] z_reg [CordicIterations+1][3];
    logic flip_reg [CordicIterations+1][3];
    logic [31:0] ph [3];

    assign ph[0] = ph_x;
    assign ph[1] = ph_y;
    assign ph[2] = ph_z;

    // Fold into [-90, 90] and load start values
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (en)
            begin
                x_reg[0][a] <= 41'sd652032874;
                y_reg[0][a] <= '0;
                if ($signed(ph[a]) > 32'sd1073741824 || $signed(ph[a]) < -32'sd1073741824)
                begin
                    z_reg[0][a] <= 41'($signed(ph[a] + 32'h8000_0000));
                    flip_reg[0][a] <= 1'b1;
                end
                else
                begin
                    z_reg[0][a] <= 41'($signed(ph[a]));
                    flip_reg[0][a] <= 1'b0;
                end
            end
        end
    end

    // Rotation stages
    for (genvar i = 0; i < CordicIterations; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (en)
                begin
                    flip_reg[i+1][a] <= flip_reg[i][a];
                    if (z_reg[i][a] >= 0)
                    begin
                        x_reg[i+1][a] <= x_reg[i][a] - (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] + (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] - atan_val(i);
                    end
                    else
                    begin
                        x_reg[i+1][a] <= x_reg[i][a] + (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] - (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] + atan_val(i);
                    end
                end
            end
        end
    end

    // Unfold and saturate
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (flip_reg[CordicIterations][a])
            begin
                cs[a] = sat_q30(-64'(x_reg[CordicIterations][a]));
                sn[a] = sat_q30(-64'(y_reg[CordicIterations][a]));
            end
            else
            begin
                cs[a] = sat_q30(64'(x_reg[CordicIterations][a]));
                sn[a] = sat_q30(64'(y_reg[CordicIterations][a]));
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/e2rm_back.sv
// Back part: CORDIC, two registered matrix products and output register
`default_nettype none
module e2rm_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  e2rm_pkg::job_t in_job,
    e2rm_mat_if.source out_ch
);
    import e2rm_pkg::*;
    `include "assert_macros.svh"

    localparam int Lat = CordicIterations + 6;

    logic en;
    logic [Lat-1:0] v_reg;
    logic [2:0] ord_reg [CordicIterations+1];
    logic signed [31:0] cs [3];
    logic signed [31:0] sn [3];
    logic signed [31:0] a_reg [3][3];
    logic signed [31:0] b_reg [3][3];
    logic signed [31:0] c_reg [3][3];
    logic signed [63:0] p1_reg [3][3][3];
    logic signed [31:0] t_reg [3][3];
    logic signed [31:0] c2_reg [3][3];
    logic signed [63:0] p2_reg [3][3][3];
    logic signed [31:0] m_reg [3][3];
    logic signed [31:0] rx [3][3];
    logic signed [31:0] ry [3][3];
    logic signed [31:0] rz [3][3];

    // Whole pipe holds when the result at its end is not taken
    assign en = !(out_ch.valid && !out_ch.ready);
    assign in_ready = en;
    assign out_ch.valid = v_reg[Lat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[Lat-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ord_reg[0] <= in_job.order;
            for (int k = 1; k < CordicIterations + 1; k++) ord_reg[k] <= ord_reg[k-1];
        end
    end

    e2rm_cordic u_cordic (
        .clk(clk), .en(en),
        .ph_x(in_job.ph_x), .ph_y(in_job.ph_y), .ph_z(in_job.ph_z),
        .cs(cs), .sn(sn)
    );

    // Elementary matrices
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                rx[i][j] = '0; ry[i][j] = '0; rz[i][j] = '0;
            end
        rx[0][0] = 32'sd1073741824;
        rx[1][1] = cs[0]; rx[1][2] = -sn[0]; rx[2][1] = sn[0]; rx[2][2] = cs[0];
        ry[0][0] = cs[1]; ry[0][2] = sn[1]; ry[1][1] = 32'sd1073741824;
        ry[2][0] = -sn[1]; ry[2][2] = cs[1];
        rz[0][0] = cs[2]; rz[0][1] = -sn[2]; rz[1][0] = sn[2]; rz[1][1] = cs[2];
        rz[2][2] = 32'sd1073741824;
    end

    // Operand selection by order (order sits at index CordicIterations+1-1)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    case (ord_reg[CordicIterations])
                        ORDER_XYZ: begin a_reg[i][j] <= rz[i][j]; b_reg[i][j] <= ry[i][j];
                                   c_reg[i][j] <= rx[i][j]; end
                        ORDER_ZYX: begin a_reg[i][j] <= rx[i][j]; b_reg[i][j] <= ry[i][j];
                                   c_reg[i][j] <= rz[i][j]; end
                        ORDER_YZX: begin a_reg[i][j] <= rx[i][j]; b_reg[i][j] <= rz[i][j];
                                   c_reg[i][j] <= ry[i][j]; end
                        ORDER_YXZ: begin a_reg[i][j] <= rz[i][j]; b_reg[i][j] <= rx[i][j];
                                   c_reg[i][j] <= ry[i][j]; end
                        ORDER_XZY: begin a_reg[i][j] <= ry[i][j]; b_reg[i][j] <= rz[i][j];
                                   c_reg[i][j] <= rx[i][j]; end
                        default:   begin a_reg[i][j] <= '0; b_reg[i][j] <= '0;
                                   c_reg[i][j] <= '0; end
                    endcase
                end
        end
    end

    // First product: multiply stage, then sum and round stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 3; k++)
                        p1_reg[i][j][k] <= 64'(a_reg[i][k]) * 64'(b_reg[k][j]);
                    c2_reg[i][j] <= c_reg[i][j];
                    t_reg[i][j] <= sat_q30((p1_reg[i][j][0] + p1_reg[i][j][1]
                        + p1_reg[i][j][2] + 64'sd536870912) >>> 30);
                end
        end
    end

    // Second product (c3 lags c2 one stage so it lines up with t)
    logic signed [31:0] c3_reg [3][3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    c3_reg[i][j] <= c2_reg[i][j];
                    for (int k = 0; k < 3; k++)
                        p2_reg[i][j][k] <= 64'(t_reg[i][k]) * 64'(c3_reg[k][j]);
                    m_reg[i][j] <= sat_q30((p2_reg[i][j][0] + p2_reg[i][j][1]
                        + p2_reg[i][j][2] + 64'sd536870912) >>> 30);
                end
        end
    end

    assign out_ch.m00 = m_reg[0][0]; assign out_ch.m01 = m_reg[0][1];
    assign out_ch.m02 = m_reg[0][2]; assign out_ch.m10 = m_reg[1][0];
    assign out_ch.m11 = m_reg[1][1]; assign out_ch.m12 = m_reg[1][2];
    assign out_ch.m20 = m_reg[2][0]; assign out_ch.m21 = m_reg[2][1];
    assign out_ch.m22 = m_reg[2][2];

    `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `ASSERT_NEXT(a_stall_pipe, clk, rst_n, !en, $stable(v_reg))
    `ASSERT_IMPLIES(a_ready, clk, rst_n, !out_ch.valid, in_ready)
endmodule
`default_nettype wire

// File: sv/euler_to_rotation_matrix_top.sv
// Top level of the Euler angles to rotation matrix block
// Usage:
//   in_ch  : valid/ready channel carrying angle_x, angle_y, angle_z
//            (degrees, 16 fractional bits).
//   out_ch : valid/ready channel carrying m00..m22 in signed Q1.30.
//   rotation_order (order_reg) is to be written by cfg_we/cfg_data only
//   while the block is idle; the block itself does not enforce this.
//   One item may enter and one matrix leave every cycle unless the
//   receiver stalls. From input accept to result valid an item passes
//   one phase stage, the queue, a CORDIC load stage, 24 CORDIC stages,
//   an operand select stage and two multiply/sum stage pairs.
//   Reset clears all valid flags and sets the order to xyz.
//   When the receiver stalls the back pipe holds; the queue absorbs
//   up to four items, then the front drops ready.
`default_nettype none
module euler_to_rotation_matrix_top (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_data,
    e2rm_angle_if.sink in_ch,
    e2rm_mat_if.source out_ch
);
    import e2rm_pkg::*;

    logic [2:0] order_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    job_t f_job, q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_XYZ;
        else if (cfg_we)
            order_reg <= cfg_data;
    end

    e2rm_front u_front (
        .clk(clk), .rst_n(rst_n), .order(order_reg), .in_ch(in_ch),
        .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
    );

    e2rm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    e2rm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
        .out_ch(out_ch)
    );
endmodule
`default_nettype wire

// File: tb/sv/euler_to_rotation_matrix_top_tb.sv
// Self-checking testbench of the Euler angles to rotation matrix block
`timescale 1ns / 100ps
`default_nettype none

import e2rm_pkg::*;

typedef longint pose_mat_t[3][3];

typedef struct {
    elem_t e[9];
} matrix_words_t;

// Works out the expected matrix per accepted pose and compares results
class rotation_scoreboard;
    matrix_words_t pending_matrices[$];
    int errors;

    localparam longint OneQ30 = 64'sd1073741824;
    localparam longint CordicStart = 64'sd652032874;

    function new();
        errors = 0;
    endfunction

    static function longint clamp_q30(longint v);
        if (v > OneQ30) return OneQ30;
        if (v < -OneQ30) return -OneQ30;
        return v;
    endfunction

    // Degrees to phase, fold to the right half plane, then CORDIC rotation
    static function void sine_cosine(longint a, output longint s, output longint c);
        longint atan_steps[32];
        longint unsigned num;
        logic [31:0] ph;
        logic [31:0] p2;
        longint z, x, y, xs, ys;
        bit flip;
        atan_steps = '{536870912, 316933406, 167458907, 85004756, 42667331,
                       21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                       333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                       1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        num = longint'(a * 65536 + 180) + (64'd360 << 32);
        ph = 32'(num / 64'd360);
        z = longint'($signed(ph));
        flip = 1'b0;
        if (z > OneQ30 || z < -OneQ30)
        begin
            p2 = ph + 32'h8000_0000;
            z = longint'($signed(p2));
            flip = 1'b1;
        end
        x = CordicStart;
        y = 0;
        for (int i = 0; i < CordicIterations && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_steps[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_steps[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = clamp_q30(x);
        s = clamp_q30(y);
    endfunction

    static function pose_mat_t mat_product(pose_mat_t p, pose_mat_t q);
        pose_mat_t r;
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += p[i][k] * q[k][j];
                r[i][j] = clamp_q30((acc + (64'sd1 << 29)) >>> 30);
            end
        return r;
    endfunction

    // Accepted pose: predict its matrix under the current order
    function void note_pose(angle_t ax, angle_t ay, angle_t az, logic [2:0] order);
        longint sx, cx, sy, cy, sz, cz;
        pose_mat_t rx, ry, rz, t, m;
        matrix_words_t w;
        sine_cosine(longint'(ax), sx, cx);
        sine_cosine(longint'(ay), sy, cy);
        sine_cosine(longint'(az), sz, cz);
        rx = '{'{OneQ30, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, OneQ30, 0}, '{-sy, 0, cy}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, OneQ30}};
        m = '{default: 0};
        case (order)
            ORDER_XYZ: begin t = mat_product(rz, ry); m = mat_product(t, rx); end
            ORDER_ZYX: begin t = mat_product(rx, ry); m = mat_product(t, rz); end
            ORDER_YZX: begin t = mat_product(rx, rz); m = mat_product(t, ry); end
            ORDER_YXZ: begin t = mat_product(rz, rx); m = mat_product(t, ry); end
            ORDER_XZY: begin t = mat_product(ry, rz); m = mat_product(t, rx); end
            default: m = '{default: 0};
        endcase
        for (int i = 0; i < 9; i++)
            w.e[i] = elem_t'(m[i / 3][i % 3]);
        pending_matrices = {pending_matrices, w};
    endfunction

    // Accepted matrix: compare with the oldest prediction
    function void check_matrix(matrix_words_t got);
        matrix_words_t want;
        string names[9];
        names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
        if (pending_matrices.size() == 0)
        begin
            $display("%0t: matrix with nothing expected, m00 %0d", $time, got.e[0]);
            errors++;
            return;
        end
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++)
            if (got.e[i] !== want.e[i])
            begin
                $display("%0t: %s expected %0d actual %0d", $time, names[i],
                         want.e[i], got.e[i]);
                errors++;
            end
    endfunction
endclass

module euler_to_rotation_matrix_top_tb;
    localparam logic [2:0] ORDER_SPARE5 = 3'd5;
    localparam logic [2:0] ORDER_SPARE6 = 3'd6;
    localparam logic [2:0] ORDER_SPARE7 = 3'd7;
    localparam int Phases = 10;
    localparam int ItemsPerPhase = 195;
    localparam int Deg180 = 11796480;
    localparam int Deg90 = 5898240;
    localparam int Deg45 = 2949120;
    localparam int SettleCycles = 40;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_data;
    logic [2:0] cur_order;
    bit quiet;
    bit long_hold;

    e2rm_angle_if in_if ();
    e2rm_mat_if out_if ();

    rotation_scoreboard sb;

    euler_to_rotation_matrix_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_if.sink),
        .out_ch   (out_if.source)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // Offer one pose and wait until it is taken
    task automatic send_pose(angle_t ax, angle_t ay, angle_t az);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.angle_x <= ax;
        in_if.angle_y <= ay;
        in_if.angle_z <= az;
        do @(negedge clk); while (!in_if.ready);
        @(posedge clk);
        sb.note_pose(ax, ay, az, cur_order);
    endtask

    task automatic write_order(logic [2:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_order = v;
    endtask

    task automatic wait_drained();
        while (sb.pending_matrices.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic angle_t pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return angle_t'($urandom());
        if (sel == 1) return angle_t'(($urandom_range(0, 8) - 4) * Deg45);
        return angle_t'(int'($urandom_range(0, 2 * Deg180)) - Deg180);
    endfunction

    // Receiver: random stalls, one long hold on request
    initial
    begin
        int stall;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_if.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(negedge clk); while (!out_if.valid);
        end
    end

    // Result monitor: valid and ready are stable by the falling edge
    always @(negedge clk)
        if (rst_n && out_if.valid && out_if.ready)
        begin
            matrix_words_t got;
            got.e = '{out_if.m00, out_if.m01, out_if.m02, out_if.m10, out_if.m11,
                      out_if.m12, out_if.m20, out_if.m21, out_if.m22};
            sb.check_matrix(got);
        end

    // Stimulus
    initial
    begin
        logic [2:0] orders[Phases];
        int edge_angles[12];
        orders = '{ORDER_XYZ, ORDER_ZYX, ORDER_YZX, ORDER_YXZ, ORDER_XZY,
                   ORDER_SPARE5, ORDER_SPARE6, ORDER_SPARE7, ORDER_XZY, ORDER_XYZ};
        edge_angles = '{0, Deg180, -Deg180, Deg90, -Deg90, Deg45, 1, -1,
                        Deg180 + 1, -Deg180 - 1, 16777215, -16777216};
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cur_order = ORDER_XYZ;
        quiet = 1'b0;
        long_hold = 1'b0;
        in_if.valid = 1'b0;
        in_if.angle_x = '0;
        in_if.angle_y = '0;
        in_if.angle_z = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < Phases; p++)
        begin
            write_order(orders[p]);
            quiet = (p % 3 == 1);
            // Directed corners on the first phase
            if (p == 0)
            begin
                foreach (edge_angles[i])
                    send_pose(angle_t'(edge_angles[i]), angle_t'(edge_angles[(i + 3) % 12]),
                              angle_t'(edge_angles[(i + 7) % 12]));
                send_pose(angle_t'(Deg180), angle_t'(Deg180), angle_t'(Deg180));
                send_pose(angle_t'(-Deg180), angle_t'(-Deg180), angle_t'(-Deg180));
            end
            // Receiver holds off while items keep coming
            if (p == 1)
                long_hold = 1'b1;
            for (int n = 0; n < ItemsPerPhase; n++)
            begin
                send_pose(pick_angle(), pick_angle(), pick_angle());
                if (p == 3 && n == ItemsPerPhase / 2)
                begin
                    in_if.valid <= 1'b0;
                    while (sb.pending_matrices.size() != 0) @(posedge clk);
                end
            end
            in_if.valid <= 1'b0;
            wait_drained();
        end

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/e2rm_pkg.sv
sv/e2rm_if.sv
sv/e2rm_front.sv
sv/e2rm_queue.sv
sv/e2rm_cordic.sv
sv/e2rm_back.sv
sv/euler_to_rotation_matrix_top.sv
tb/sv/euler_to_rotation_matrix_top_tb.sv
